FILE: rtl/hhq_pkg.sv
// Shared types for the heightfield height query block.
// Controller commands, datapath status and operation codes.
// No dependencies.
package hhq_pkg;

  localparam logic CFG_ACROSS = 1'b0;
  localparam logic CFG_DOWN   = 1'b1;

  typedef enum logic [1:0] {
    VR_P,
    VR_A,
    VR_B
  } vrole_e;

  typedef enum logic [4:0] {
    M_NONE,
    M_E0A,
    M_E0B,
    M_E1A,
    M_E1B,
    M_E2A,
    M_E2B,
    M_NYA,
    M_NYB,
    M_NXA,
    M_NXB,
    M_NZA,
    M_NZB,
    M_UXL,
    M_UXH,
    M_UZL,
    M_UZH
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADDSH
  } acc_op_e;

  typedef enum logic [1:0] {
    RES_MISS,
    RES_FLAT,
    RES_DIV
  } res_kind_e;

  typedef struct packed {
    logic      wr_en;
    logic      q_load;
    logic      walk_clear;
    logic      walk_next;
    logic      rd_en;
    vrole_e    rd_role;
    mul_sel_e  mul_sel;
    acc_op_e   acc_op;
    logic      st_nx;
    logic      st_ny;
    logic      st_nz;
    logic      div_start;
    logic      res_load;
    res_kind_e res_kind;
  } hhq_cmd_t;

  typedef struct packed {
    logic acc_neg;
    logic ny_zero;
    logic walk_last;
    logic walk_empty;
    logic div_busy;
    logic out_free;
  } hhq_sts_t;

endpackage

FILE: rtl/hhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hhq_ctrl.sv
// Sequencer for the heightfield height query: walks triangles, drives the datapath.
// Depends on hhq_pkg.
module hhq_ctrl import hhq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  input  hhq_sts_t sts_i,
  output hhq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRI,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e    state_q, state_d;
  logic [4:0] step_q, step_d;
  res_kind_e kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    kind_d  = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_mode_i) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.q_load     = 1'b1;
            cmd_o.walk_clear = 1'b1;
            step_d           = 5'd0;
            if (sts_i.walk_empty) begin
              state_d = ST_OUT;
              kind_d  = RES_MISS;
            end else begin
              state_d = ST_TRI;
            end
          end
        end
      end
      ST_TRI: begin
        step_d = step_q + 5'd1;
        case (step_q)
          5'd0: begin cmd_o.rd_en = 1'b1; cmd_o.rd_role = VR_P; end
          5'd1: begin cmd_o.rd_en = 1'b1; cmd_o.rd_role = VR_A; end
          5'd2: begin cmd_o.rd_en = 1'b1; cmd_o.rd_role = VR_B; end
          5'd4: begin cmd_o.mul_sel = M_E0A; cmd_o.acc_op = ACC_LOAD; end
          5'd5: begin cmd_o.mul_sel = M_E0B; cmd_o.acc_op = ACC_SUB; end
          5'd6: begin cmd_o.mul_sel = M_E1A; cmd_o.acc_op = ACC_LOAD; end
          5'd7: begin cmd_o.mul_sel = M_E1B; cmd_o.acc_op = ACC_SUB; end
          5'd8: begin cmd_o.mul_sel = M_E2A; cmd_o.acc_op = ACC_LOAD; end
          5'd9: begin cmd_o.mul_sel = M_E2B; cmd_o.acc_op = ACC_SUB; end
          5'd10: begin cmd_o.mul_sel = M_NYA; cmd_o.acc_op = ACC_LOAD; end
          5'd11: begin cmd_o.mul_sel = M_NYB; cmd_o.acc_op = ACC_SUB; end
          5'd12: begin cmd_o.mul_sel = M_NXA; cmd_o.acc_op = ACC_LOAD; end
          5'd13: begin
            cmd_o.mul_sel = M_NXB; cmd_o.acc_op = ACC_SUB; cmd_o.st_ny = 1'b1;
          end
          5'd14: begin cmd_o.mul_sel = M_NZA; cmd_o.acc_op = ACC_LOAD; end
          5'd15: begin
            cmd_o.mul_sel = M_NZB; cmd_o.acc_op = ACC_SUB; cmd_o.st_nx = 1'b1;
          end
          5'd17: cmd_o.st_nz = 1'b1;
          5'd18: begin cmd_o.mul_sel = M_UXL; cmd_o.acc_op = ACC_LOAD; end
          5'd19: begin cmd_o.mul_sel = M_UXH; cmd_o.acc_op = ACC_ADDSH; end
          5'd20: begin cmd_o.mul_sel = M_UZL; cmd_o.acc_op = ACC_ADD; end
          5'd21: begin cmd_o.mul_sel = M_UZH; cmd_o.acc_op = ACC_ADDSH; end
          5'd23: begin
            if (sts_i.ny_zero) begin
              state_d = ST_OUT;
              kind_d  = RES_FLAT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end
          end
          default: ;
        endcase
        // edge results are checked once the product register and then the accumulator have taken their last product
        if ((step_q == 5'd7 || step_q == 5'd9 || step_q == 5'd11) && sts_i.acc_neg) begin
          if (sts_i.walk_last) begin
            state_d = ST_OUT;
            kind_d  = RES_MISS;
          end else begin
            cmd_o.walk_next = 1'b1;
            step_d          = 5'd0;
          end
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT;
          kind_d  = RES_DIV;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = kind_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 5'd0;
      kind_q  <= RES_MISS;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      kind_q  <= kind_d;
    end
  end

endmodule

FILE: rtl/hhq_dp.sv
// Datapath for the heightfield height query: vertex RAM, shared multiplier,
// accumulator, restoring divider, walk counters and result register.
// Depends on hhq_pkg and hhq_ram.
module hhq_dp import hhq_pkg::*; #(
  parameter int unsigned MAX_CELLS  = 16,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_addr_i,
  input  logic [4:0]                   cfg_data_i,
  input  logic [4:0]                   in_row_i,
  input  logic [4:0]                   in_col_i,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] vz_i,
  input  logic signed [COORD_BITS-1:0] qx_i,
  input  logic signed [COORD_BITS-1:0] qz_i,
  input  hhq_cmd_t                     cmd_i,
  output hhq_sts_t                     sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_height_o,
  output logic                         out_found_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned GRID  = MAX_CELLS + 1;
  localparam int unsigned DEPTH = GRID * GRID;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(GRID);
  localparam int unsigned L     = C + 2;
  localparam int unsigned NW    = 2 * C + 3;
  localparam int unsigned PW    = 2 * C + 4;
  localparam int unsigned W     = 3 * C + 6;
  localparam int unsigned RW    = 2 * C + 4;
  localparam int unsigned KW    = $clog2(W + 1);

  typedef struct packed {
    logic signed [C-1:0] z;
    logic signed [C-1:0] y;
    logic signed [C-1:0] x;
  } vtx_t;

  function automatic logic signed [C:0] dif(logic signed [C-1:0] u, logic signed [C-1:0] v);
    return (C+1)'(u) - (C+1)'(v);
  endfunction

  // configuration and walk counters
  logic [4:0]    across_q, down_q;
  logic [31:0]   ca32, cd32;
  logic [CW-1:0] ca, cd, r_q, c_q;
  logic          pass_q;
  logic          c_end, r_end;

  assign ca32  = (32'(across_q) > MAX_CELLS) ? 32'(MAX_CELLS) : 32'(across_q);
  assign cd32  = (32'(down_q) > MAX_CELLS) ? 32'(MAX_CELLS) : 32'(down_q);
  assign ca    = ca32[CW-1:0];
  assign cd    = cd32[CW-1:0];
  assign c_end = (c_q == CW'(ca - 1'b1));
  assign r_end = (r_q == CW'(cd - 1'b1));

  // vertex memory
  logic          wr_ok;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] rd_row, rd_col;
  logic [3*C-1:0] rdata;
  logic          rd_vld_q;
  vrole_e        rd_role_q;

  assign wr_ok = cmd_i.wr_en && (32'(in_row_i) <= MAX_CELLS) && (32'(in_col_i) <= MAX_CELLS);
  assign waddr = AW'(32'(in_row_i) * GRID + 32'(in_col_i));

  always_comb begin
    rd_row = r_q;
    rd_col = c_q;
    case (cmd_i.rd_role)
      VR_P: begin
        rd_row = pass_q ? r_q : CW'(r_q + 1'b1);
        rd_col = pass_q ? CW'(c_q + 1'b1) : c_q;
      end
      VR_A: begin
        rd_row = pass_q ? CW'(r_q + 1'b1) : r_q;
        rd_col = pass_q ? CW'(c_q + 1'b1) : c_q;
      end
      VR_B: begin
        rd_row = pass_q ? r_q : CW'(r_q + 1'b1);
        rd_col = pass_q ? c_q : CW'(c_q + 1'b1);
      end
      default: ;
    endcase
  end

  assign raddr = AW'(32'(rd_row) * GRID + 32'(rd_col));

  hhq_ram #(
    .WIDTH (3 * C),
    .DEPTH (DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (waddr),
    .wdata_i ({vz_i, vy_i, vx_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // multiplier and accumulator
  vtx_t               p_q, a_q, b_q, f, t;
  logic signed [C-1:0] qx_q, qz_q;
  logic signed [C:0]   mul_a;
  logic signed [C+2:0] mul_b;
  logic signed [PW-1:0] prod_q;
  logic signed [W-1:0]  acc_q, acc_d;
  acc_op_e             acc_op_q;
  logic signed [NW-1:0] nx_q, ny_q, nz_q, n_sel;
  logic                 n_high;

  always_comb begin
    f      = p_q;
    t      = a_q;
    n_sel  = nx_q;
    n_high = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.mul_sel)
      M_E1A, M_E1B: begin f = a_q; t = b_q; end
      M_E2A, M_E2B: begin f = b_q; t = p_q; end
      default: ;
    endcase
    case (cmd_i.mul_sel)
      M_E0A, M_E1A, M_E2A: begin
        mul_a = dif(t.z, f.z);
        mul_b = (C+3)'(dif(qx_q, f.x));
      end
      M_E0B, M_E1B, M_E2B: begin
        mul_a = dif(t.x, f.x);
        mul_b = (C+3)'(dif(qz_q, f.z));
      end
      M_NYA: begin mul_a = dif(a_q.z, p_q.z); mul_b = (C+3)'(dif(b_q.x, p_q.x)); end
      M_NYB: begin mul_a = dif(a_q.x, p_q.x); mul_b = (C+3)'(dif(b_q.z, p_q.z)); end
      M_NXA: begin mul_a = dif(a_q.y, p_q.y); mul_b = (C+3)'(dif(b_q.z, p_q.z)); end
      M_NXB: begin mul_a = dif(a_q.z, p_q.z); mul_b = (C+3)'(dif(b_q.y, p_q.y)); end
      M_NZA: begin mul_a = dif(a_q.x, p_q.x); mul_b = (C+3)'(dif(b_q.y, p_q.y)); end
      M_NZB: begin mul_a = dif(a_q.y, p_q.y); mul_b = (C+3)'(dif(b_q.x, p_q.x)); end
      M_UXL, M_UXH, M_UZL, M_UZH: begin
        if (cmd_i.mul_sel == M_UZL || cmd_i.mul_sel == M_UZH) begin
          mul_a = dif(qz_q, p_q.z);
          n_sel = nz_q;
        end else begin
          mul_a = dif(qx_q, p_q.x);
        end
        n_high = (cmd_i.mul_sel == M_UXH || cmd_i.mul_sel == M_UZH);
        if (n_high) begin
          mul_b = (C+3)'($signed(n_sel[NW-1:L]));
        end else begin
          mul_b = $signed({1'b0, n_sel[L-1:0]});
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    case (acc_op_q)
      ACC_LOAD:  acc_d = W'(prod_q);
      ACC_ADD:   acc_d = acc_q + W'(prod_q);
      ACC_SUB:   acc_d = acc_q - W'(prod_q);
      ACC_ADDSH: acc_d = acc_q + (W'(prod_q) <<< L);
      default:   ;
    endcase
  end

  // restoring divider on magnitudes
  logic [W-1:0]  nmag_q, quo_q;
  logic [NW-1:0] den_q;
  logic [RW-1:0] rem_q, trial;
  logic          neg_q;
  logic [KW-1:0] cnt_q;
  logic          fits;

  assign trial = {rem_q[RW-2:0], nmag_q[W-1]};
  assign fits  = (trial >= RW'(den_q));

  // final height
  logic               big;
  logic [C+1:0]       qm;
  logic signed [C+2:0] qs, hd;
  logic signed [C-1:0] h_div;

  always_comb begin
    big = |quo_q[W-1:C+1];
    qm  = big ? {1'b1, {(C+1){1'b0}}} : quo_q[C+1:0];
    qs  = neg_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    hd  = (C+3)'(p_q.y) - qs;
    if (hd[C+2:C-1] == '0 || hd[C+2:C-1] == '1) begin
      h_div = hd[C-1:0];
    end else if (hd[C+2]) begin
      h_div = {1'b1, {(C-1){1'b0}}};
    end else begin
      h_div = {1'b0, {(C-1){1'b1}}};
    end
  end

  logic               out_valid_q;
  logic signed [C-1:0] out_height_q;
  logic               out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q    <= 5'd1;
      down_q      <= 5'd1;
      r_q         <= '0;
      c_q         <= '0;
      pass_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_role_q   <= VR_P;
      acc_op_q    <= ACC_NONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_ACROSS) begin
          across_q <= cfg_data_i;
        end else begin
          down_q <= cfg_data_i;
        end
      end
      if (cmd_i.walk_clear) begin
        r_q    <= '0;
        c_q    <= '0;
        pass_q <= 1'b0;
      end else if (cmd_i.walk_next) begin
        if (c_end) begin
          c_q <= '0;
          if (r_end) begin
            r_q    <= '0;
            pass_q <= 1'b1;
          end else begin
            r_q <= CW'(r_q + 1'b1);
          end
        end else begin
          c_q <= CW'(c_q + 1'b1);
        end
      end
      rd_vld_q  <= cmd_i.rd_en;
      rd_role_q <= cmd_i.rd_role;
      acc_op_q  <= cmd_i.acc_op;
      if (cmd_i.div_start) begin
        cnt_q <= KW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= KW'(cnt_q - 1'b1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      qx_q <= qx_i;
      qz_q <= qz_i;
    end
    if (rd_vld_q) begin
      case (rd_role_q)
        VR_P:    p_q <= rdata;
        VR_A:    a_q <= rdata;
        default: b_q <= rdata;
      endcase
    end
    prod_q <= PW'(mul_a) * PW'(mul_b);
    acc_q  <= acc_d;
    if (cmd_i.st_nx) nx_q <= acc_q[NW-1:0];
    if (cmd_i.st_ny) ny_q <= acc_q[NW-1:0];
    if (cmd_i.st_nz) nz_q <= acc_q[NW-1:0];
    if (cmd_i.div_start) begin
      nmag_q <= acc_q[W-1] ? W'(-acc_q) : W'(acc_q);
      den_q  <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      neg_q  <= acc_q[W-1] ^ ny_q[NW-1];
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cnt_q != '0) begin
      nmag_q <= {nmag_q[W-2:0], 1'b0};
      rem_q  <= fits ? RW'(trial - RW'(den_q)) : trial;
      quo_q  <= {quo_q[W-2:0], fits};
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        RES_FLAT: begin out_height_q <= p_q.y; out_found_q <= 1'b1; end
        RES_DIV:  begin out_height_q <= h_div; out_found_q <= 1'b1; end
        default:  begin out_height_q <= '0;    out_found_q <= 1'b0; end
      endcase
    end
  end

  assign sts_o.acc_neg    = acc_q[W-1];
  assign sts_o.ny_zero    = (ny_q == '0);
  assign sts_o.walk_last  = pass_q && r_end && c_end;
  assign sts_o.walk_empty = (ca == '0) || (cd == '0);
  assign sts_o.div_busy   = (cnt_q != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_height_o = out_height_q;
  assign out_found_o  = out_found_q;

endmodule

FILE: rtl/heightfield_height_query.sv
// Heightfield height query top level: stream ports, controller and datapath.
// Vertex write: accepted while idle. Query: accepted while idle, then each triangle runs the
// shared multiplier sequence and is rejected at its first failing edge test; a sloped hit
// adds a restoring divide, then the result is loaded into the output register and is
// valid the cycle after. One request at a time.
// Reset: cells_across and cells_down to 1; vertex RAM undefined until written.
module heightfield_height_query import hhq_pkg::*; #(
  parameter int unsigned MAX_CELLS  = 16,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_addr_i,
  input  logic [4:0] cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // grid_row, grid_col, vertex_x, vertex_y, vertex_z, query_x, query_z
  input  logic [((10+5*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // height
  output logic [((COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // found
  output logic m_axis_tuser
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned ODW = ((C + 7) / 8) * 8;

  hhq_cmd_t cmd;
  hhq_sts_t sts;
  logic signed [C-1:0] height;

  hhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hhq_dp #(
    .MAX_CELLS  (MAX_CELLS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_row_i     (s_axis_tdata[4:0]),
    .in_col_i     (s_axis_tdata[9:5]),
    .vx_i         (s_axis_tdata[10 +: C]),
    .vy_i         (s_axis_tdata[10+C +: C]),
    .vz_i         (s_axis_tdata[10+2*C +: C]),
    .qx_i         (s_axis_tdata[10+3*C +: C]),
    .qz_i         (s_axis_tdata[10+4*C +: C]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_height_o (height),
    .out_found_o  (m_axis_tuser)
  );

  assign m_axis_tdata = ODW'(unsigned'(height));

endmodule
